[sv/pbu_pkg.sv]
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types and constants for the packed bitmap unpacker.
// ----------------------------------------------------------------------------
package pbu_pkg;

  // register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd3;

  // pixel formats
  localparam logic [2:0] FMT_GRAY8 = 3'd0;
  localparam logic [2:0] FMT_MONO  = 3'd1;
  localparam logic [2:0] FMT_GRAY2 = 3'd2;
  localparam logic [2:0] FMT_GRAY4 = 3'd3;

  // counter width and saturation
  localparam int CNT_W   = 13;
  localparam int CNT_MAX = 8191;

  // default limits
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_PITCH = 4096;
  localparam int DEF_MAX_ROWS  = 4096;

  // job queue depth
  localparam int QUEUE_DEPTH = 2;

  // one classified input byte, handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] fmt;
    logic [3:0] count;       // pixels to emit, 1..8
    logic       row_end;     // last pixel of this word ends a row
    logic       bitmap_end;  // last pixel of this word ends the bitmap
    logic       err;         // invalid format word
  } job_t;

endpackage

[sv/packed_bitmap_unpacker.sv]
// ----------------------------------------------------------------------------
// packed_bitmap_unpacker
// Expands packed 1/2/4/8-bit bitmap bytes into one byte per pixel.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in         in_valid/in_ready    packed_byte
//  out      out        out_valid/out_ready  pixel_value, last_of_byte, row_end,
//                                           bitmap_end, format_error
//
// The back end emits one pixel per cycle while the output is not stalled; a
// word gives up to 8 pixels in mono, 4 in gray2, 2 in gray4, and 1 in gray8
// or on an invalid format; padding words give none. The front takes a word
// per cycle while the two-entry job queue has room. Reset clears registers
// and row position; there is no clearing pass. A stalled output holds the
// back end, which fills the queue and then drops in_ready.
// ----------------------------------------------------------------------------
module packed_bitmap_unpacker
  import pbu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_PITCH = DEF_MAX_PITCH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            packed_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_value,
  output logic                  last_of_byte,
  output logic                  row_end,
  output logic                  bitmap_end,
  output logic                  format_error
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // classify words
  pbu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PITCH (MAX_PITCH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .packed_byte (packed_byte),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  // job queue
  pbu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // pixel expansion
  pbu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_job      (pop_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .last_of_byte (last_of_byte),
    .row_end      (row_end),
    .bitmap_end   (bitmap_end),
    .format_error (format_error)
  );

endmodule

[sv/pbu_queue.sv]
// ----------------------------------------------------------------------------
// pbu_queue
// Small job queue between front and back, valid/ready on both sides.
// ----------------------------------------------------------------------------
module pbu_queue
  import pbu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (level != LVL_W'(QUEUE_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

[sv/pbu_front.sv]
// ----------------------------------------------------------------------------
// pbu_front
// Holds the registers and row position, classifies each input word into a job.
// ----------------------------------------------------------------------------
module pbu_front
  import pbu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_PITCH = DEF_MAX_PITCH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            packed_byte,
  output logic                  push_valid,
  input  logic                  push_ready,
  output job_t                  push_job
);

  localparam int LIM_W = (MAX_WIDTH > CNT_MAX) ? CNT_MAX : MAX_WIDTH;
  localparam int LIM_P = (MAX_PITCH > CNT_MAX) ? CNT_MAX : MAX_PITCH;
  localparam int LIM_R = (MAX_ROWS  > CNT_MAX) ? CNT_MAX : MAX_ROWS;

  logic [2:0]       pixel_format;
  logic [CNT_W-1:0] row_width;
  logic [CNT_W-1:0] row_pitch;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] pixel_column;
  logic [CNT_W-1:0] byte_in_row;
  logic [CNT_W-1:0] row_index;

  logic [CNT_W-1:0] width_c;
  logic [CNT_W-1:0] pitch_c;
  logic [CNT_W-1:0] rows_c;
  logic             fmt_bad;
  logic             active;
  logic [3:0]       ppb;
  logic [CNT_W-1:0] left;
  logic [3:0]       n;
  logic [CNT_W-1:0] col_sum;
  logic [CNT_W-1:0] bir_inc;
  logic             row_done;
  logic             last_row;
  logic             accept;

  // clamped register values
  assign width_c = (row_width > CNT_W'(LIM_W)) ? CNT_W'(LIM_W) : row_width;
  assign pitch_c = (row_pitch > CNT_W'(LIM_P)) ? CNT_W'(LIM_P) : row_pitch;
  assign rows_c  = (row_count > CNT_W'(LIM_R)) ? CNT_W'(LIM_R) : row_count;

  // classify the word
  always_comb begin
    fmt_bad = (pixel_format > FMT_GRAY4);
    active  = !fmt_bad && (row_index < rows_c);
    case (pixel_format)
      FMT_MONO:  ppb = 4'd8;
      FMT_GRAY2: ppb = 4'd4;
      FMT_GRAY4: ppb = 4'd2;
      default:   ppb = 4'd1;
    endcase
    left = (pixel_column < width_c) ? (width_c - pixel_column) : '0;
    n    = (left < CNT_W'(ppb)) ? left[3:0] : ppb;
    col_sum  = pixel_column + CNT_W'(n);
    bir_inc  = (byte_in_row == CNT_W'(CNT_MAX)) ? byte_in_row : byte_in_row + 1'b1;
    row_done = (bir_inc >= pitch_c) && (col_sum >= width_c);
    last_row = ({1'b0, row_index} + 1'b1) == {1'b0, rows_c};
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (fmt_bad || (active && (n != 4'd0)));

  // job descriptor
  always_comb begin
    push_job.data       = packed_byte;
    push_job.fmt        = pixel_format;
    push_job.err        = fmt_bad;
    push_job.count      = fmt_bad ? 4'd1 : n;
    push_job.row_end    = !fmt_bad && (col_sum == width_c);
    push_job.bitmap_end = !fmt_bad && (col_sum == width_c) && last_row;
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= '0;
      row_width    <= '0;
      row_pitch    <= '0;
      row_count    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[2:0];
        REG_ROW_WIDTH:    row_width    <= cfg_data;
        REG_ROW_PITCH:    row_pitch    <= cfg_data;
        REG_ROW_COUNT:    row_count    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // row position
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      byte_in_row  <= '0;
      row_index    <= '0;
    end else if (accept && active) begin
      if (row_done) begin
        pixel_column <= '0;
        byte_in_row  <= '0;
        row_index    <= row_index + 1'b1;
      end else begin
        pixel_column <= col_sum;
        byte_in_row  <= bir_inc;
      end
    end
  end

endmodule

[sv/pbu_back.sv]
// ----------------------------------------------------------------------------
// pbu_back
// Expands a job into pixels, one per unstalled cycle, via an output register.
// ----------------------------------------------------------------------------
module pbu_back
  import pbu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  job_t       pop_job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_value,
  output logic       last_of_byte,
  output logic       row_end,
  output logic       bitmap_end,
  output logic       format_error
);

  logic       busy;
  job_t       cur;
  logic       adv;
  logic       last_px;
  logic [7:0] pix;
  logic [7:0] shifted;

  assign adv       = busy && (!out_valid || out_ready);
  assign last_px   = (cur.count == 4'd1);
  assign pop_ready = !busy || (adv && last_px);

  // pixel at the top of the shifter
  always_comb begin
    case (cur.fmt)
      FMT_MONO: begin
        pix     = cur.data[7] ? 8'hFF : 8'h00;
        shifted = {cur.data[6:0], 1'b0};
      end
      FMT_GRAY2: begin
        pix     = cur.data & 8'hC0;
        shifted = {cur.data[5:0], 2'b00};
      end
      FMT_GRAY4: begin
        pix     = cur.data & 8'hF0;
        shifted = {cur.data[3:0], 4'h0};
      end
      default: begin
        pix     = cur.data;
        shifted = cur.data;
      end
    endcase
    if (cur.err) begin
      pix = 8'h00;
    end
  end

  // current job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop_valid && pop_ready) begin
      busy <= 1'b1;
    end else if (adv && last_px) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_job;
    end else if (adv) begin
      cur.data  <= shifted;
      cur.count <= cur.count - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_value  <= pix;
      last_of_byte <= last_px;
      row_end      <= last_px && cur.row_end;
      bitmap_end   <= last_px && cur.bitmap_end;
      format_error <= cur.err;
    end
  end

endmodule
